### design/mepc_pkg.sv
package mepc_pkg;

   // field widths
   localparam int COORD_W = 32;
   localparam int ITER_W  = 7;
   localparam int COLOR_W = 8;

   // parameter defaults
   localparam int FRAC_BITS_DEFAULT         = 28;
   localparam int PRIME_TABLE_DEPTH_DEFAULT = 100;

   localparam logic [ITER_W-1:0]  MAX_ITER_RESET = 7'd50;
   localparam logic [COLOR_W-1:0] INSIDE_COLOR   = 8'd255;

   // first 128 primes; the color is the low byte
   localparam logic [15:0] PRIME_ROM [128] = '{
      16'd2,   16'd3,   16'd5,   16'd7,   16'd11,  16'd13,  16'd17,  16'd19,  16'd23,  16'd29,
      16'd31,  16'd37,  16'd41,  16'd43,  16'd47,  16'd53,  16'd59,  16'd61,  16'd67,  16'd71,
      16'd73,  16'd79,  16'd83,  16'd89,  16'd97,  16'd101, 16'd103, 16'd107, 16'd109, 16'd113,
      16'd127, 16'd131, 16'd137, 16'd139, 16'd149, 16'd151, 16'd157, 16'd163, 16'd167, 16'd173,
      16'd179, 16'd181, 16'd191, 16'd193, 16'd197, 16'd199, 16'd211, 16'd223, 16'd227, 16'd229,
      16'd233, 16'd239, 16'd241, 16'd251, 16'd257, 16'd263, 16'd269, 16'd271, 16'd277, 16'd281,
      16'd283, 16'd293, 16'd307, 16'd311, 16'd313, 16'd317, 16'd331, 16'd337, 16'd347, 16'd349,
      16'd353, 16'd359, 16'd367, 16'd373, 16'd379, 16'd383, 16'd389, 16'd397, 16'd401, 16'd409,
      16'd419, 16'd421, 16'd431, 16'd433, 16'd439, 16'd443, 16'd449, 16'd457, 16'd461, 16'd463,
      16'd467, 16'd479, 16'd487, 16'd491, 16'd499, 16'd503, 16'd509, 16'd521, 16'd523, 16'd541,
      16'd547, 16'd557, 16'd563, 16'd569, 16'd571, 16'd577, 16'd587, 16'd593, 16'd599, 16'd601,
      16'd607, 16'd613, 16'd617, 16'd619, 16'd631, 16'd641, 16'd643, 16'd647, 16'd653, 16'd659,
      16'd661, 16'd673, 16'd677, 16'd683, 16'd691, 16'd701, 16'd709, 16'd719
   };

   function automatic logic [COLOR_W-1:0] prime_color(input logic [ITER_W-1:0] idx);
      prime_color = PRIME_ROM[idx][COLOR_W-1:0];
   endfunction

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_CHK
   } mepc_state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic advance;
      logic finish_escape;
      logic finish_inside;
   } mepc_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic escape;
      logic last;
      logic zero_iter;
   } mepc_status_type;

endpackage

### design/mandelbrot_escape_prime_color_unit.sv
// Mandelbrot escape-time unit: an item (point c, signed fixed point) is taken when start is
// high and busy is low; z = z*z + c is run from z = 0 for up to max_iterations steps, and
// the result appears on the rsp_ ports for exactly one cycle with rsp_valid high. The
// receiver cannot stall it, so it must capture the result in that cycle. Each complex step
// runs through the steps partial-product multiply, product sum, and magnitude check and z
// update; busy stays high while an item runs its s steps (escape step + 1, or max_iterations
// if it stays inside), and its result is on the ports in the first cycle with busy low;
// the next item can be taken in that same cycle. With max_iterations = 0 the result is on
// the ports in the cycle after the start and busy never rises. Write csr_ only while the
// unit is idle.
module mandelbrot_escape_prime_color_unit
   import mepc_pkg::*;
#(
   parameter int FRAC_BITS         = FRAC_BITS_DEFAULT,
   parameter int PRIME_TABLE_DEPTH = PRIME_TABLE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  logic signed [COORD_W-1:0]  req_c_real,
   input  logic signed [COORD_W-1:0]  req_c_imag,
   output logic                       rsp_valid,
   output logic [COLOR_W-1:0]         rsp_color_value,
   output logic                       rsp_escaped,
   output logic [ITER_W-1:0]          rsp_escape_step,
   input  logic                       csr_write_enable,
   input  logic [ITER_W-1:0]          csr_write_data
);

   mepc_cmd_type    cmd;
   mepc_status_type status;

   // sequencer
   mepc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // iteration datapath and config register
   mepc_datapath #(
      .FRAC_BITS         (FRAC_BITS),
      .PRIME_TABLE_DEPTH (PRIME_TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_c_real       (req_c_real),
      .req_c_imag       (req_c_imag),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .rsp_color_value  (rsp_color_value),
      .rsp_escaped      (rsp_escaped),
      .rsp_escape_step  (rsp_escape_step)
   );

endmodule

### design/mepc_mul.sv
module mepc_mul
   import mepc_pkg::*;
#(
   parameter int ZW = 34
) (
   input  logic                  clock,
   input  logic signed [ZW-1:0]  op_a,
   input  logic signed [ZW-1:0]  op_b,
   output logic signed [2*ZW-1:0] product
);

   localparam int HW  = ZW - 32;
   localparam int PRW = 2 * ZW;

   logic [31:0]          a_lo, b_lo;
   logic signed [HW-1:0] a_hi, b_hi;

   logic [63:0]            p_ll_in, p_ll_ff;
   logic signed [32+HW:0]  p_lh_in, p_lh_ff;
   logic signed [32+HW:0]  p_hl_in, p_hl_ff;
   logic signed [2*HW-1:0] p_hh_in, p_hh_ff;
   logic signed [PRW-1:0]  product_in, product_ff;

   // split operands: unsigned low word, signed high part
   assign a_lo = op_a[31:0];
   assign b_lo = op_b[31:0];
   assign a_hi = op_a[ZW-1:32];
   assign b_hi = op_b[ZW-1:32];

   // stage 1: four partial products, each at most about 33 x 33
   always_comb begin
      p_ll_in = a_lo * b_lo;
      p_lh_in = $signed({1'b0, a_lo}) * b_hi;
      p_hl_in = a_hi * $signed({1'b0, b_lo});
      p_hh_in = a_hi * b_hi;
   end

   // stage 2: weighted sum into the full signed product
   always_comb begin
      product_in = PRW'($signed({1'b0, p_ll_ff}))
                 + (PRW'(p_lh_ff) <<< 32)
                 + (PRW'(p_hl_ff) <<< 32)
                 + (PRW'(p_hh_ff) <<< 64);
   end

   always_ff @(posedge clock) begin
      p_ll_ff    <= p_ll_in;
      p_lh_ff    <= p_lh_in;
      p_hl_ff    <= p_hl_in;
      p_hh_ff    <= p_hh_in;
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

### design/mepc_datapath.sv
module mepc_datapath
   import mepc_pkg::*;
#(
   parameter int FRAC_BITS         = FRAC_BITS_DEFAULT,
   parameter int PRIME_TABLE_DEPTH = PRIME_TABLE_DEPTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mepc_cmd_type               cmd,
   output mepc_status_type            status,
   input  logic signed [COORD_W-1:0]  req_c_real,
   input  logic signed [COORD_W-1:0]  req_c_imag,
   input  logic                       csr_write_enable,
   input  logic [ITER_W-1:0]          csr_write_data,
   output logic [COLOR_W-1:0]         rsp_color_value,
   output logic                       rsp_escaped,
   output logic [ITER_W-1:0]          rsp_escape_step
);

   // z stays below 2^(max(FRAC_BITS+2,31)+1) while it is carried on; one bit of margin
   localparam int ZW  = (FRAC_BITS + 5 > 34) ? FRAC_BITS + 5 : 34;
   localparam int PRW = 2 * ZW;
   localparam int PW  = PRW - FRAC_BITS;
   localparam int IW  = (PRIME_TABLE_DEPTH > 1) ? $clog2(PRIME_TABLE_DEPTH) : 1;
   localparam logic [PW:0]   MAG_LIMIT = {{(PW-2){1'b0}}, 3'b100} << FRAC_BITS;
   localparam logic [IW-1:0] IDX_LAST  = IW'(PRIME_TABLE_DEPTH - 1);

   logic [ITER_W-1:0]         max_iter_in, max_iter_ff;
   logic signed [COORD_W-1:0] c_real_in, c_real_ff, c_imag_in, c_imag_ff;
   logic signed [ZW-1:0]      zr_in, zr_ff, zi_in, zi_ff;
   logic [ITER_W-1:0]         step_in, step_ff;
   logic [IW-1:0]             idx_in, idx_ff;
   logic [COLOR_W-1:0]        color_in, color_ff;
   logic                      escaped_in, escaped_ff;
   logic [ITER_W-1:0]         esc_step_in, esc_step_ff;

   logic signed [PRW-1:0] prod_rr, prod_ii, prod_ri;
   logic [PW-1:0]         sq_r, sq_i;
   logic signed [PW:0]    twice_ri;
   logic [PW:0]           mag;

   // squares and the cross product of the current z
   mepc_mul #(.ZW(ZW)) u_mul_rr (.clock(clock), .op_a(zr_ff), .op_b(zr_ff), .product(prod_rr));
   mepc_mul #(.ZW(ZW)) u_mul_ii (.clock(clock), .op_a(zi_ff), .op_b(zi_ff), .product(prod_ii));
   mepc_mul #(.ZW(ZW)) u_mul_ri (.clock(clock), .op_a(zr_ff), .op_b(zi_ff), .product(prod_ri));

   // truncate back to fixed point; cross product keeps one extra bit for the factor two
   assign sq_r     = prod_rr[PRW-1:FRAC_BITS];
   assign sq_i     = prod_ii[PRW-1:FRAC_BITS];
   assign twice_ri = prod_ri[PRW-1:FRAC_BITS-1];
   assign mag      = {1'b0, sq_r} + {1'b0, sq_i};

   always_comb begin
      status.escape    = mag > MAG_LIMIT;
      status.last      = step_ff == (max_iter_ff - ITER_W'(1));
      status.zero_iter = max_iter_ff == '0;
   end

   // iteration state
   always_comb begin
      c_real_in = c_real_ff;
      c_imag_in = c_imag_ff;
      zr_in     = zr_ff;
      zi_in     = zi_ff;
      step_in   = step_ff;
      idx_in    = idx_ff;
      if (cmd.load) begin
         // first step from z = 0 lands on z = c
         c_real_in = req_c_real;
         c_imag_in = req_c_imag;
         zr_in     = ZW'(req_c_real);
         zi_in     = ZW'(req_c_imag);
         step_in   = '0;
         idx_in    = '0;
      end else if (cmd.advance) begin
         zr_in   = sq_r[ZW-1:0] - sq_i[ZW-1:0] + ZW'(c_real_ff);
         zi_in   = twice_ri[ZW-1:0] + ZW'(c_imag_ff);
         step_in = step_ff + ITER_W'(1);
         idx_in  = (idx_ff == IDX_LAST) ? '0 : idx_ff + IW'(1);
      end
   end

   // result capture
   always_comb begin
      color_in    = color_ff;
      escaped_in  = escaped_ff;
      esc_step_in = esc_step_ff;
      if (cmd.finish_escape) begin
         color_in    = prime_color(ITER_W'(idx_ff));
         escaped_in  = 1'b1;
         esc_step_in = step_ff;
      end else if (cmd.finish_inside) begin
         color_in    = INSIDE_COLOR;
         escaped_in  = 1'b0;
         esc_step_in = max_iter_ff;
      end
   end

   // config register
   assign max_iter_in = csr_write_enable ? csr_write_data : max_iter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= MAX_ITER_RESET;
      end else begin
         max_iter_ff <= max_iter_in;
      end
   end

   always_ff @(posedge clock) begin
      c_real_ff   <= c_real_in;
      c_imag_ff   <= c_imag_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      step_ff     <= step_in;
      idx_ff      <= idx_in;
      color_ff    <= color_in;
      escaped_ff  <= escaped_in;
      esc_step_ff <= esc_step_in;
   end

   assign rsp_color_value = color_ff;
   assign rsp_escaped     = escaped_ff;
   assign rsp_escape_step = esc_step_ff;

endmodule

### design/mepc_ctrl.sv
module mepc_ctrl
   import mepc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   output logic            rsp_valid,
   input  mepc_status_type status,
   output mepc_cmd_type    cmd
);

   mepc_state_type state_in, state_ff;
   logic           rsp_valid_in, rsp_valid_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && !status.zero_iter) state_in = ST_MUL;
         end
         ST_MUL: state_in = ST_SUM;
         ST_SUM: state_in = ST_CHK;
         ST_CHK: begin
            if (status.escape || status.last) state_in = ST_IDLE;
            else state_in = ST_MUL;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load          = 1'b1;
               cmd.finish_inside = status.zero_iter;
            end
         end
         ST_MUL, ST_SUM: ;
         ST_CHK: begin
            if (status.escape) cmd.finish_escape = 1'b1;
            else if (status.last) cmd.finish_inside = 1'b1;
            else cmd.advance = 1'b1;
         end
         default: ;
      endcase
   end

   // one-cycle result strobe
   assign rsp_valid_in = cmd.finish_escape || cmd.finish_inside;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
